// File: src/csa_pkg.sv
package csa_pkg;

  localparam int PARTICLE_COUNT = 1024;
  localparam int ADDR_W = $clog2(PARTICLE_COUNT);
  localparam int POS_W = 31;
  localparam int ENTRY_W = 3 * POS_W;
  localparam logic [31:0] MASS_RESET = 32'h0001_0000;

  localparam logic [2:0] OP_FRONT  = 3'd0;
  localparam logic [2:0] OP_BACK   = 3'd1;
  localparam logic [2:0] OP_LEFT   = 3'd2;
  localparam logic [2:0] OP_RIGHT  = 3'd3;
  localparam logic [2:0] OP_TOP    = 3'd4;
  localparam logic [2:0] OP_BOTTOM = 3'd5;
  localparam logic [2:0] OP_PAIR   = 3'd6;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [9:0]         first_index;
    logic [POS_W-1:0]   first_pos_x;
    logic [POS_W-1:0]   first_pos_y;
    logic [POS_W-1:0]   first_pos_z;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic signed [31:0] first_vel_z;
    logic [9:0]         second_index;
    logic [POS_W-1:0]   second_pos_x;
    logic [POS_W-1:0]   second_pos_y;
    logic [POS_W-1:0]   second_pos_z;
  } event_t;

  typedef struct packed {
    logic signed [63:0] pulse_front;
    logic signed [63:0] pulse_back;
    logic signed [63:0] pulse_left;
    logic signed [63:0] pulse_right;
    logic signed [63:0] pulse_top;
    logic signed [63:0] pulse_bottom;
    logic [62:0]        path_sum;
    logic [31:0]        path_count;
  } stats_t;

  typedef struct packed {
    logic load_event;
    logic clear_wr;
    logic rd_second;
    logic cap_first;
    logic cap_second;
    logic wr_first;
    logic wr_second;
    logic mul;
    logic pulse_acc;
    logic diff;
    logic square;
    logic sum;
    logic sqrt_start;
    logic path_acc;
    logic slot;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic [2:0] opcode;
    logic       visit_ok;
    logic       sqrt_done;
  } status_t;

endpackage

// File: src/csa_event_if.sv
interface csa_event_if;
  logic                valid;
  logic                ready;
  csa_pkg::event_t     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/csa_stats_if.sv
interface csa_stats_if;
  logic                valid;
  logic                ready;
  csa_pkg::stats_t     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/csa_isqrt.sv
module csa_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import csa_pkg::*;

  logic [63:0] rad;
  logic [32:0] rem;
  logic [4:0]  count;
  logic        busy;
  logic [34:0] rem_shift;
  logic [34:0] trial;
  logic        fits;

  // One result bit per cycle, restoring method, two radicand bits consumed per step.
  assign rem_shift = {rem, rad[63:62]};
  assign trial     = {1'b0, root, 2'b01};
  assign fits      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad   <= radicand;
      rem   <= '0;
      root  <= '0;
      count <= '0;
    end else if (busy) begin
      rem   <= fits ? 33'(rem_shift - trial) : rem_shift[32:0];
      root  <= {root[30:0], fits};
      rad   <= {rad[61:0], 2'b00};
      count <= count + 5'd1;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("square root started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("square root done while still busy");

endmodule

// File: src/csa_datapath.sv
module csa_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  csa_pkg::event_t   evt_data,
  input  csa_pkg::cmd_t     cmd,
  output csa_pkg::status_t  status,
  output csa_pkg::stats_t   stats_data
);
  import csa_pkg::*;

  localparam logic [63:0] SIGN64 = {1'b1, 63'd0};

  function automatic logic [POS_W-1:0] absdiff(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  logic [31:0]         mass;
  event_t              evt;
  logic [ENTRY_W-1:0]  mem [PARTICLE_COUNT];
  logic [ENTRY_W-1:0]  mem_q;
  logic [ENTRY_W-1:0]  old_first;
  logic [ENTRY_W-1:0]  old_second;
  logic [ADDR_W-1:0]   clear_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic                wr_en;
  logic [ENTRY_W-1:0]  wr_data;
  logic                first_ok;
  logic                second_ok;

  logic [63:0]         pulse [6];
  logic [62:0]         path_total;
  logic [31:0]         path_tally;

  logic [31:0]         vel;
  logic                vneg;
  logic [31:0]         vmag;
  logic                flip;
  logic [63:0]         prod;
  logic [63:0]         mag;
  logic                mag_neg;
  logic [63:0]         wall_sum;
  logic [63:0]         offset;
  logic [64:0]         add_res;
  logic [64:0]         sub_res;
  logic [63:0]         sat_res;
  logic [63:0]         pulse_new;

  logic [ENTRY_W-1:0]  cur_pos;
  logic [ENTRY_W-1:0]  old_pos;
  logic [POS_W-1:0]    dx;
  logic [POS_W-1:0]    dy;
  logic [POS_W-1:0]    dz;
  logic [2*POS_W-1:0]  sx;
  logic [2*POS_W-1:0]  sy;
  logic [2*POS_W-1:0]  sz;
  logic [63:0]         sq_sum;
  logic [31:0]         root;
  logic                sqrt_done;
  logic [63:0]         path_add;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass <= MASS_RESET;
    end else if (cfg_wr_en) begin
      mass <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_event) begin
      evt <= evt_data;
    end
  end

  assign first_ok  = {22'd0, evt.first_index} < 32'(PARTICLE_COUNT);
  assign second_ok = {22'd0, evt.second_index} < 32'(PARTICLE_COUNT);

  // Position store: one write port shared by the clearing pass and the updates.
  always_comb begin
    rd_addr = cmd.rd_second ? ADDR_W'(evt.second_index) : ADDR_W'(evt.first_index);
    wr_en   = 1'b0;
    wr_addr = clear_addr;
    wr_data = '0;
    if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (cmd.wr_first) begin
      wr_en   = first_ok;
      wr_addr = ADDR_W'(evt.first_index);
      wr_data = {evt.first_pos_x, evt.first_pos_y, evt.first_pos_z};
    end else if (cmd.wr_second) begin
      wr_en   = second_ok;
      wr_addr = ADDR_W'(evt.second_index);
      wr_data = {evt.second_pos_x, evt.second_pos_y, evt.second_pos_z};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_wr) begin
      clear_addr <= clear_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_first) begin
      old_first <= mem_q;
    end
    if (cmd.cap_second) begin
      old_second <= mem_q;
    end
  end

  // Wall momentum: 2 * mass * |v|, sign from the speed and from the wall.
  always_comb begin
    case (evt.opcode)
      OP_FRONT, OP_BACK: vel = evt.first_vel_y;
      OP_LEFT, OP_RIGHT: vel = evt.first_vel_x;
      default:           vel = evt.first_vel_z;
    endcase
    vneg = vel[31];
    vmag = vneg ? (~vel + 32'd1) : vel;
    flip = (evt.opcode == OP_BACK) || (evt.opcode == OP_RIGHT) || (evt.opcode == OP_TOP);
  end

  assign prod = 64'(mass) * 64'(vmag);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mag     <= {prod[62:0], 1'b0};
      mag_neg <= vneg ^ flip;
    end
  end

  always_comb begin
    case (evt.opcode)
      OP_FRONT:  wall_sum = pulse[0];
      OP_BACK:   wall_sum = pulse[1];
      OP_LEFT:   wall_sum = pulse[2];
      OP_RIGHT:  wall_sum = pulse[3];
      OP_TOP:    wall_sum = pulse[4];
      default:   wall_sum = pulse[5];
    endcase
    // Offset binary turns signed saturation into unsigned clamping.
    offset  = wall_sum ^ SIGN64;
    add_res = {1'b0, offset} + {1'b0, mag};
    sub_res = {1'b0, offset} - {1'b0, mag};
    if (mag_neg) begin
      sat_res = sub_res[64] ? '0 : sub_res[63:0];
    end else begin
      sat_res = add_res[64] ? '1 : add_res[63:0];
    end
    pulse_new = sat_res ^ SIGN64;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        pulse[k] <= '0;
      end
    end else if (cmd.pulse_acc) begin
      for (int k = 0; k < 6; k++) begin
        if (evt.opcode == 3'(k)) begin
          pulse[k] <= pulse_new;
        end
      end
    end
  end

  // Free path of the particle in the current slot.
  assign cur_pos = cmd.slot ? {evt.second_pos_x, evt.second_pos_y, evt.second_pos_z}
                            : {evt.first_pos_x, evt.first_pos_y, evt.first_pos_z};
  assign old_pos = cmd.slot ? old_second : old_first;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx <= absdiff(cur_pos[3*POS_W-1:2*POS_W], old_pos[3*POS_W-1:2*POS_W]);
      dy <= absdiff(cur_pos[2*POS_W-1:POS_W], old_pos[2*POS_W-1:POS_W]);
      dz <= absdiff(cur_pos[POS_W-1:0], old_pos[POS_W-1:0]);
    end
    if (cmd.square) begin
      sx <= (2*POS_W)'(dx) * (2*POS_W)'(dx);
      sy <= (2*POS_W)'(dy) * (2*POS_W)'(dy);
      sz <= (2*POS_W)'(dz) * (2*POS_W)'(dz);
    end
    if (cmd.sum) begin
      sq_sum <= 64'(sx) + 64'(sy) + 64'(sz);
    end
  end

  csa_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (sq_sum),
    .done     (sqrt_done),
    .root     (root)
  );

  assign path_add = {1'b0, path_total} + 64'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      path_total <= '0;
      path_tally <= '0;
    end else if (cmd.path_acc) begin
      path_total <= path_add[63] ? '1 : path_add[62:0];
      if (path_tally != '1) begin
        path_tally <= path_tally + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      stats_data.pulse_front  <= pulse[0];
      stats_data.pulse_back   <= pulse[1];
      stats_data.pulse_left   <= pulse[2];
      stats_data.pulse_right  <= pulse[3];
      stats_data.pulse_top    <= pulse[4];
      stats_data.pulse_bottom <= pulse[5];
      stats_data.path_sum     <= path_total;
      stats_data.path_count   <= path_tally;
    end
  end

  assign status.clear_last = clear_addr == ADDR_W'(PARTICLE_COUNT - 1);
  assign status.opcode     = evt.opcode;
  assign status.visit_ok   = (cmd.slot ? second_ok : first_ok) && (old_pos != '0);
  assign status.sqrt_done  = sqrt_done;

  a_path_hold: assert property (@(posedge clk) disable iff (rst)
      !$past(rst) && !$past(cmd.path_acc) |-> $stable(path_total) && $stable(path_tally))
    else $error("free path sums changed without an accumulate");
  a_tally_mono: assert property (@(posedge clk) disable iff (rst)
      !$past(rst) |-> path_tally >= $past(path_tally))
    else $error("free path count went down");

endmodule

// File: src/csa_ctrl.sv
module csa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  csa_pkg::status_t  status,
  output csa_pkg::cmd_t     cmd
);
  import csa_pkg::*;

  localparam logic [4:0] S_CLEAR      = 5'd0;
  localparam logic [4:0] S_IDLE       = 5'd1;
  localparam logic [4:0] S_DISPATCH   = 5'd2;
  localparam logic [4:0] S_RD1        = 5'd3;
  localparam logic [4:0] S_RD2        = 5'd4;
  localparam logic [4:0] S_CAP2       = 5'd5;
  localparam logic [4:0] S_WR1        = 5'd6;
  localparam logic [4:0] S_WR2        = 5'd7;
  localparam logic [4:0] S_MUL        = 5'd8;
  localparam logic [4:0] S_PULSE      = 5'd9;
  localparam logic [4:0] S_VISIT      = 5'd10;
  localparam logic [4:0] S_DIFF       = 5'd11;
  localparam logic [4:0] S_SQUARE     = 5'd12;
  localparam logic [4:0] S_SUM        = 5'd13;
  localparam logic [4:0] S_ROOT_START = 5'd14;
  localparam logic [4:0] S_ROOT       = 5'd15;
  localparam logic [4:0] S_ACC        = 5'd16;
  localparam logic [4:0] S_OUT        = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       slot;
  logic       slot_next;
  logic       is_pair;
  logic       is_wall;
  logic       more_slots;

  assign is_pair    = status.opcode == OP_PAIR;
  assign is_wall    = status.opcode <= OP_BOTTOM;
  assign more_slots = !slot && is_pair;

  always_comb begin
    state_next = state;
    slot_next  = slot;
    cmd        = '0;
    cmd.slot   = slot;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_event = 1'b1;
          slot_next      = 1'b0;
          state_next     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = (is_wall || is_pair) ? S_RD1 : S_OUT;
      end
      S_RD1: begin
        state_next = S_RD2;
      end
      S_RD2: begin
        // Both lookups of a pair item finish before either position is written back.
        cmd.cap_first = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = is_pair ? S_CAP2 : S_WR1;
      end
      S_CAP2: begin
        cmd.cap_second = 1'b1;
        state_next     = S_WR1;
      end
      S_WR1: begin
        cmd.wr_first = 1'b1;
        state_next   = is_pair ? S_WR2 : S_MUL;
      end
      S_WR2: begin
        cmd.wr_second = 1'b1;
        state_next    = S_VISIT;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_PULSE;
      end
      S_PULSE: begin
        cmd.pulse_acc = 1'b1;
        state_next    = S_VISIT;
      end
      S_VISIT: begin
        if (status.visit_ok) begin
          state_next = S_DIFF;
        end else if (more_slots) begin
          slot_next  = 1'b1;
          state_next = S_VISIT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_ROOT_START;
      end
      S_ROOT_START: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_ROOT;
      end
      S_ROOT: begin
        if (status.sqrt_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.path_acc = 1'b1;
        if (more_slots) begin
          slot_next  = 1'b1;
          state_next = S_VISIT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      slot      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
      cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule

// File: src/collision_stats_accumulator.sv
// An item of an unused opcode goes straight to its result. A wall item updates one position
// and its wall pulse, a pair item updates two positions; a wall item has at most one free
// path and a pair at most two, and each free path goes through the bit-serial square root.
// One item is in work at a time; the next can be taken in the cycle after its result is loaded.
// Reset is synchronous and active high; a clearing pass then zeroes all 1024 entries of the
// position store, and no item is accepted until it ends (mass writes are taken).
module collision_stats_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  csa_event_if.sink          collision,
  csa_stats_if.source        stats
);
  import csa_pkg::*;

  cmd_t    cmd;
  status_t status;

  csa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (collision.valid),
    .in_ready  (collision.ready),
    .out_valid (stats.valid),
    .out_ready (stats.ready),
    .status    (status),
    .cmd       (cmd)
  );

  csa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .evt_data    (collision.data),
    .cmd         (cmd),
    .status      (status),
    .stats_data  (stats.data)
  );

endmodule
